[hdl/qs_pkg.sv]
package qs_pkg;

	localparam int DATA_W = 32;

	// Commands from the sequencer to the range stack. Push and pop never coincide.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

endpackage

[hdl/qs_if.sv]
interface qs_item_if;
	logic                             valid;
	logic                             ready;
	logic signed [qs_pkg::DATA_W-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface qs_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [qs_pkg::DATA_W-1:0] sorted_value;
	logic                             end_of_set;
	logic                             overflow;

	modport source (output valid, output sorted_value, output end_of_set, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_set, input overflow,
		output ready);
endinterface

[hdl/qs_range_stack.sv]
module qs_range_stack #(
	parameter int DEPTH = 64,
	parameter int EW    = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  qs_pkg::stk_cmd_t cmd,
	input  logic [EW-1:0]    wdata,
	output logic [EW-1:0]    rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);

	logic [EW-1:0] stack_mem [DEPTH];
	logic [PW-1:0] sp_q;
	logic [PW-1:0] sp_dec;
	logic [EW-1:0] rdata_q;

	assign sp_dec = sp_q - PW'(1);
	assign empty  = (sp_q == '0);
	assign rdata  = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			priority if (cmd.push) begin
				if (sp_q < PW'(DEPTH)) begin
					sp_q <= sp_q + PW'(1);
				end
			end else if (cmd.pop) begin
				if (sp_q != '0) begin
					sp_q <= sp_dec;
				end
			end
		end
	end

	// A push onto a full stack is dropped, as is a pop from an empty one.
	always_ff @(posedge clk) begin
		if (cmd.push && sp_q < PW'(DEPTH)) begin
			stack_mem[sp_q[AW-1:0]] <= wdata;
		end
		if (cmd.pop && sp_q != '0) begin
			rdata_q <= stack_mem[sp_dec[AW-1:0]];
		end
	end

endmodule

[hdl/quicksort_engine.sv]
// Channel   Role    Payload                               Request accepted when
// items     sink    value, last                           valid && ready
// results   source  sorted_value, end_of_set, overflow    valid && ready
//
// Loading takes one cycle per request; ready is high only while the block loads a set.
// A partition of a range runs all its accesses through the single read and write port of
// the element memory; each swap adds a write state for either entry (S_SWAPR, S_SWAPW).
// Results follow at one per cycle from the registered memory read; back-pressure on results
// stalls the read-out only. No clearing pass is needed after reset.
module quicksort_engine #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	qs_item_if.sink     items,
	qs_result_if.source results
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = 2 * IW;
	localparam int DW = qs_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_LOAD,
		S_POP,
		S_RANGE,
		S_PIVOT,
		S_SCAN,
		S_SWAPR,
		S_SWAPW,
		S_FINR,
		S_FINW,
		S_PUSH2,
		S_OUT_START,
		S_OUT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           dropped_q;
	logic [IW-1:0]  lo_q, hi_q, i_q, j_q, k_q;
	logic [DW-1:0]  pivot_q, vj_q;
	logic [EW-1:0]  push2_q;
	logic           res_valid_q, res_end_q, res_ovf_q;
	logic [DW-1:0]  res_value_q;

	logic [DW-1:0]  elem_mem [CAPACITY];
	logic [DW-1:0]  rdata_q;

	logic           mem_rd_en, mem_wr_en;
	logic [IW-1:0]  mem_rd_addr, mem_wr_addr;
	logic [DW-1:0]  mem_wr_data;

	qs_pkg::stk_cmd_t stk_cmd;
	logic [EW-1:0]  stk_wdata, stk_rdata;
	logic           stk_empty;

	logic           accept, has_room, le, swap, scan_more, rng_ok, slot_free, k_end;
	logic           left_ok, right_ok, left_big;
	logic [CW-1:0]  count_nx, last_idx;
	logic [IW-1:0]  rng_lo, rng_hi, i_adv, i_inc, j_inc;
	logic [EW-1:0]  left_ent, right_ent;

	assign items.ready = (state_q == S_LOAD);
	assign accept      = items.valid && items.ready;
	assign has_room    = (count_q < CW'(CAPACITY));
	assign count_nx    = has_room ? count_q + CW'(1) : count_q;
	assign last_idx    = count_nx - CW'(1);

	assign rng_lo = stk_rdata[EW-1:IW];
	assign rng_hi = stk_rdata[IW-1:0];
	assign rng_ok = (rng_lo < rng_hi) && (CW'(rng_hi) < CW'(CAPACITY));

	// Equal values count as not greater, so they gather left of the pivot.
	assign le        = $signed(rdata_q) <= $signed(pivot_q);
	assign swap      = le && (i_q != j_q);
	assign i_inc     = i_q + IW'(1);
	assign i_adv     = le ? i_inc : i_q;
	assign j_inc     = j_q + IW'(1);
	assign scan_more = (j_inc < hi_q);

	assign left_ok   = {1'b0, i_q} > ({1'b0, lo_q} + (IW+1)'(1));
	assign right_ok  = ({1'b0, i_q} + (IW+1)'(1)) < {1'b0, hi_q};
	assign left_big  = (i_q - lo_q) >= (hi_q - i_q);
	assign left_ent  = {lo_q, i_q - IW'(1)};
	assign right_ent = {i_inc, hi_q};

	assign slot_free = !res_valid_q || results.ready;
	assign k_end     = (CW'(k_q) + CW'(1)) == count_q;

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		stk_cmd     = '0;
		stk_wdata   = '0;
		unique case (state_q)
			S_LOAD: begin
				mem_wr_en   = accept && has_room;
				mem_wr_addr = count_q[IW-1:0];
				mem_wr_data = items.value;
				if (accept && items.last && count_nx >= CW'(2)) begin
					stk_cmd.push = 1'b1;
					stk_wdata    = {IW'(0), last_idx[IW-1:0]};
				end
			end
			S_POP: begin
				stk_cmd.pop = 1'b1;
			end
			S_RANGE: begin
				mem_rd_en   = rng_ok;
				mem_rd_addr = rng_hi;
			end
			S_PIVOT: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = lo_q;
			end
			S_SCAN: begin
				mem_rd_en = 1'b1;
				priority if (swap) begin
					mem_rd_addr = i_q;
				end else if (scan_more) begin
					mem_rd_addr = j_inc;
				end else begin
					mem_rd_addr = i_adv;
				end
			end
			S_SWAPR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = j_q;
				mem_wr_data = rdata_q;
			end
			S_SWAPW: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = i_q;
				mem_wr_data = vj_q;
				mem_rd_en   = 1'b1;
				mem_rd_addr = scan_more ? j_inc : i_inc;
			end
			S_FINR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = hi_q;
				mem_wr_data = rdata_q;
			end
			S_FINW: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = i_q;
				mem_wr_data = pivot_q;
				// The larger side goes down first so the smaller one is sorted next.
				priority if (left_ok && right_ok) begin
					stk_cmd.push = 1'b1;
					stk_wdata    = left_big ? left_ent : right_ent;
				end else if (left_ok) begin
					stk_cmd.push = 1'b1;
					stk_wdata    = left_ent;
				end else if (right_ok) begin
					stk_cmd.push = 1'b1;
					stk_wdata    = right_ent;
				end
			end
			S_PUSH2: begin
				stk_cmd.push = 1'b1;
				stk_wdata    = push2_q;
			end
			S_OUT_START: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = '0;
			end
			S_OUT: begin
				mem_rd_en   = slot_free && !k_end;
				mem_rd_addr = k_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	// Accesses are serialised by the sequencer, so a read never meets a write to its entry.
	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			elem_mem[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd_en) begin
			rdata_q <= elem_mem[mem_rd_addr];
		end
	end

	qs_range_stack #(
		.DEPTH (CAPACITY),
		.EW    (EW)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.wdata  (stk_wdata),
		.rdata  (stk_rdata),
		.empty  (stk_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			pivot_q     <= '0;
			vj_q        <= '0;
			push2_q     <= '0;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_end_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (items.last) begin
							state_q <= (count_nx < CW'(2)) ? S_OUT_START : S_POP;
						end
					end
				end
				S_POP: begin
					state_q <= S_RANGE;
				end
				S_RANGE: begin
					lo_q <= rng_lo;
					hi_q <= rng_hi;
					if (rng_ok) begin
						state_q <= S_PIVOT;
					end else begin
						state_q <= stk_empty ? S_OUT_START : S_POP;
					end
				end
				S_PIVOT: begin
					pivot_q <= rdata_q;
					i_q     <= lo_q;
					j_q     <= lo_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (swap) begin
						vj_q    <= rdata_q;
						state_q <= S_SWAPR;
					end else begin
						i_q <= i_adv;
						j_q <= j_inc;
						if (!scan_more) begin
							state_q <= S_FINR;
						end
					end
				end
				S_SWAPR: begin
					state_q <= S_SWAPW;
				end
				S_SWAPW: begin
					i_q     <= i_inc;
					j_q     <= j_inc;
					state_q <= scan_more ? S_SCAN : S_FINR;
				end
				S_FINR: begin
					state_q <= S_FINW;
				end
				S_FINW: begin
					priority if (left_ok && right_ok) begin
						push2_q <= left_big ? right_ent : left_ent;
						state_q <= S_PUSH2;
					end else if (left_ok || right_ok) begin
						state_q <= S_POP;
					end else begin
						state_q <= stk_empty ? S_OUT_START : S_POP;
					end
				end
				S_PUSH2: begin
					state_q <= S_POP;
				end
				S_OUT_START: begin
					k_q     <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_value_q <= rdata_q;
						res_end_q   <= k_end;
						res_ovf_q   <= dropped_q;
						if (k_end) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_LOAD;
						end else begin
							k_q <= k_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign results.valid        = res_valid_q;
	assign results.sorted_value = res_value_q;
	assign results.end_of_set   = res_end_q;
	assign results.overflow     = res_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.pop |-> !stk_empty)
		else $error("range stack popped while empty");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (i_q <= j_q && j_q < hi_q && lo_q <= i_q))
		else $error("partition indices out of order");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH2) |=> (state_q == S_POP && !stk_empty))
		else $error("second subrange not held on the stack");

endmodule
